/* src/gnc_pkg.sv */
// gnc_pkg: shared types and constants for the group nesting checker.
// Holds port widths, grouping kinds, error codes and the cell token.
// No dependencies.
package gnc_pkg;

   localparam int DeltaW         = 32;
   localparam int KindW          = 2;
   localparam int IdW            = 16;
   localparam int ErrW           = 3;
   localparam int ReqDataW       = 48;   // time_delta, group_id
   localparam int RspDataW       = 8;    // error_code, track_ok, pad
   localparam int MaxGroupsDef   = 16;
   localparam int GroupIdBitsDef = 16;

   localparam logic [KindW-1:0] KIND_NONE     = 2'd0;
   localparam logic [KindW-1:0] KIND_START    = 2'd1;
   localparam logic [KindW-1:0] KIND_ENCLOSED = 2'd2;
   localparam logic [KindW-1:0] KIND_END      = 2'd3;

   localparam logic [ErrW-1:0] ERR_NONE            = 3'd0;
   localparam logic [ErrW-1:0] ERR_DUP_START       = 3'd1;
   localparam logic [ErrW-1:0] ERR_ORPHAN_ENCLOSED = 3'd2;
   localparam logic [ErrW-1:0] ERR_ORPHAN_END      = 3'd3;
   localparam logic [ErrW-1:0] ERR_ZERO_DURATION   = 3'd4;
   localparam logic [ErrW-1:0] ERR_OPEN_AT_END     = 3'd5;
   localparam logic [ErrW-1:0] ERR_TABLE_FULL      = 3'd6;

   // token walking the cell row; scan pass collects, commit pass updates
   typedef struct packed {
      logic active;
      logic commit;
      logic dnz;          // time_delta nonzero
      logic claim;        // commit: take first free entry
      logic drop;         // commit: drop first matching entry
      logic done;         // commit: action already taken upstream
      logic hit;          // scan: key found
      logic hit_elapsed;  // scan: elapsed flag of first hit
      logic free;         // scan: a free entry exists
      logic open;         // commit: some entry valid afterwards
   } tok_type;

   function automatic logic [ErrW-1:0] note_err(input logic [ErrW-1:0] cur,
                                                 input logic [ErrW-1:0] code);
      return (cur == ERR_NONE) ? code : cur;
   endfunction

endpackage

/* src/gnc_cell.sv */
// gnc_cell: one table entry of the group nesting checker.
// Holds valid, key and elapsed flags and forwards the token one cell per cycle.
// Depends on gnc_pkg.
module gnc_cell #(
   parameter int KEY_W = gnc_pkg::GroupIdBitsDef
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [KEY_W-1:0] key_i,
   input  logic             clr_i,
   input  gnc_pkg::tok_type tok_i,
   output gnc_pkg::tok_type tok_o
);

   logic             valid_ff, valid_in;
   logic             elapsed_ff, elapsed_in;
   logic [KEY_W-1:0] key_ff, key_in;
   gnc_pkg::tok_type tok_ff, tok_in;
   logic             match;

   assign match = valid_ff && (key_ff == key_i);

   always_comb begin
      valid_in   = valid_ff;
      elapsed_in = elapsed_ff;
      key_in     = key_ff;
      tok_in     = tok_i;
      if (clr_i) begin
         valid_in   = 1'b0;
         elapsed_in = 1'b0;
      end else if (tok_i.active) begin
         if (!tok_i.commit) begin
            if (valid_ff && tok_i.dnz) begin
               elapsed_in = 1'b1;
            end
            if (!tok_i.hit && match) begin
               tok_in.hit_elapsed = elapsed_ff || tok_i.dnz;
            end
            tok_in.hit  = tok_i.hit || match;
            tok_in.free = tok_i.free || !valid_ff;
         end else begin
            if (tok_i.claim && !tok_i.done && !valid_ff) begin
               valid_in    = 1'b1;
               key_in      = key_i;
               elapsed_in  = 1'b0;
               tok_in.done = 1'b1;
            end
            if (tok_i.drop && !tok_i.done && match) begin
               valid_in    = 1'b0;
               elapsed_in  = 1'b0;
               tok_in.done = 1'b1;
            end
            tok_in.open = tok_i.open || valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         elapsed_ff <= 1'b0;
         tok_ff     <= '0;
      end else begin
         valid_ff   <= valid_in;
         elapsed_ff <= elapsed_in;
         tok_ff     <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign tok_o = tok_ff;

`ifndef SYNTHESIS
   a_clr_empties: assert property (@(posedge clock) disable iff (reset)
      clr_i |=> (!valid_ff && !elapsed_ff))
      else $error("cell not empty after clear");
   a_elapsed_valid: assert property (@(posedge clock) disable iff (reset)
      elapsed_ff |-> valid_ff)
      else $error("elapsed flag on free entry");
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (tok_i.active && tok_i.commit && tok_i.done && !clr_i) |=> $stable(valid_ff))
      else $error("entry changed after commit action was taken");
`endif

endmodule

/* src/group_nesting_checker_core.sv */
// group_nesting_checker_core: top level of the group nesting checker.
// Controller, result register and the row of gnc_cell entries.
// Depends on gnc_pkg and gnc_cell.

// Checks timed events against group open/close rules and returns one
// response per request carrying the first error of the current track; on
// the request with tlast set the response also carries the verdict and the
// table of open groups is cleared. A request is taken only while idle;
// before the next one is taken, a token walks the row of MAX_GROUPS entry
// cells once to look up the group id and once to apply the update, one
// cell per cycle, and the result is emitted. A finished response waits in the
// output register while the next request is already being processed; that
// next request stalls only while the earlier response is still not taken.
module group_nesting_checker_core #(
   parameter int MAX_GROUPS    = gnc_pkg::MaxGroupsDef,
   parameter int GROUP_ID_BITS = gnc_pkg::GroupIdBitsDef
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [gnc_pkg::ReqDataW-1:0] req_tdata,  // time_delta[31:0], group_id[47:32]
   input  logic [gnc_pkg::KindW-1:0]    req_tuser,  // grouping_kind[1:0]
   input  logic                         req_tlast,  // last_event
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [gnc_pkg::RspDataW-1:0] rsp_tdata,  // error_code[2:0], track_ok[3], zero[7:4]
   output logic                         rsp_tlast   // track_end
);

   localparam int KeyW = (GROUP_ID_BITS < gnc_pkg::IdW) ? GROUP_ID_BITS : gnc_pkg::IdW;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_COMMIT = 4'b0100,
      S_EMIT   = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [KeyW-1:0]               key_ff, key_in;
   logic [gnc_pkg::KindW-1:0]     kind_ff, kind_in;
   logic                          last_ff, last_in;
   logic [gnc_pkg::ErrW-1:0]      err_ff, err_in;
   logic [gnc_pkg::ErrW-1:0]      res_err_ff, res_err_in;
   logic                          res_last_ff, res_last_in;
   gnc_pkg::tok_type              inj_ff, inj_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [gnc_pkg::ErrW-1:0]      rsp_err_ff, rsp_err_in;
   logic                          rsp_ok_ff, rsp_ok_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          clr;
   logic [gnc_pkg::ErrW-1:0]      fin_err;
   gnc_pkg::tok_type              tok [MAX_GROUPS+1];
   gnc_pkg::tok_type              tok_out;

   assign tok[0]  = inj_ff;
   assign tok_out = tok[MAX_GROUPS];

   for (genvar g = 0; g < MAX_GROUPS; g++) begin : g_cell
      gnc_cell #(
         .KEY_W (KeyW)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .key_i (key_ff),
         .clr_i (clr),
         .tok_i (tok[g]),
         .tok_o (tok[g+1])
      );
   end

   assign fin_err = (last_ff && tok_out.open) ?
                    gnc_pkg::note_err(err_ff, gnc_pkg::ERR_OPEN_AT_END) : err_ff;

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      res_err_in   = res_err_ff;
      res_last_in  = res_last_ff;
      inj_in       = '0;
      clr          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_err_in   = rsp_err_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               key_in        = req_tdata[gnc_pkg::DeltaW +: KeyW];
               kind_in       = req_tuser;
               last_in       = req_tlast;
               inj_in.active = 1'b1;
               inj_in.dnz    = |req_tdata[gnc_pkg::DeltaW-1:0];
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (tok_out.active) begin
               inj_in.active = 1'b1;
               inj_in.commit = 1'b1;
               case (kind_ff)
                  gnc_pkg::KIND_START: begin
                     if (tok_out.hit) begin
                        err_in = gnc_pkg::note_err(err_ff, gnc_pkg::ERR_DUP_START);
                     end else if (!tok_out.free) begin
                        err_in = gnc_pkg::note_err(err_ff, gnc_pkg::ERR_TABLE_FULL);
                     end else begin
                        inj_in.claim = 1'b1;
                     end
                  end
                  gnc_pkg::KIND_ENCLOSED: begin
                     if (!tok_out.hit) begin
                        err_in = gnc_pkg::note_err(err_ff, gnc_pkg::ERR_ORPHAN_ENCLOSED);
                     end
                  end
                  gnc_pkg::KIND_END: begin
                     if (!tok_out.hit) begin
                        err_in = gnc_pkg::note_err(err_ff, gnc_pkg::ERR_ORPHAN_END);
                     end else if (!tok_out.hit_elapsed) begin
                        err_in = gnc_pkg::note_err(err_ff, gnc_pkg::ERR_ZERO_DURATION);
                     end else begin
                        inj_in.drop = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (tok_out.active) begin
               res_err_in  = fin_err;
               res_last_in = last_ff;
               if (last_ff) begin
                  err_in = gnc_pkg::ERR_NONE;
                  clr    = 1'b1;
               end else begin
                  err_in = fin_err;
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = res_err_ff;
               rsp_ok_in    = res_last_ff && (res_err_ff == gnc_pkg::ERR_NONE);
               rsp_last_in  = res_last_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         err_ff       <= gnc_pkg::ERR_NONE;
         inj_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         err_ff       <= err_in;
         inj_ff       <= inj_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      kind_ff     <= kind_in;
      last_ff     <= last_in;
      res_err_ff  <= res_err_in;
      res_last_ff <= res_last_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(gnc_pkg::RspDataW - gnc_pkg::ErrW - 1){1'b0}}, rsp_ok_ff, rsp_err_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_idle_no_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !tok_out.active)
      else $error("token returned while idle");
   a_err_range: assert property (@(posedge clock) disable iff (reset)
      err_ff != 3'd7)
      else $error("sticky error holds an unused code");
   a_ok_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ok_ff) |-> (rsp_last_ff && rsp_err_ff == gnc_pkg::ERR_NONE))
      else $error("track_ok set without clean track end");
`endif

endmodule

/* verif/group_nesting_checker_scoreboard.sv */
// Response checker for group_nesting_checker_core: predicts one verdict per request
// and compares every accepted response with the oldest pending one.
// Depends on gnc_pkg.
module group_nesting_checker_scoreboard
   import gnc_pkg::*;
#(
   parameter int MAX_GROUPS    = MaxGroupsDef,
   parameter int GROUP_ID_BITS = GroupIdBitsDef
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic [KindW-1:0]    req_tuser,
   input  logic                req_tlast,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RspDataW-1:0] rsp_tdata,
   input  logic                rsp_tlast,
   output int                  mismatches,
   output int                  verdicts_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [IdW-1:0] KeyMask =
      (GROUP_ID_BITS >= IdW) ? '1 : IdW'((64'd1 << GROUP_ID_BITS) - 64'd1);

   typedef struct packed {
      logic [ErrW-1:0] err;
      logic            track_end;
      logic            track_ok;
   } verdict_type;

   verdict_type     verdicts_due[$];
   logic            grp_open [MAX_GROUPS];
   logic [IdW-1:0]  grp_key  [MAX_GROUPS];
   logic            grp_aged [MAX_GROUPS];
   logic [ErrW-1:0] track_err;

   initial begin
      mismatches       = 0;
      verdicts_pending = 0;
   end

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("%0t ns: %s got %0d, expected %0d", $time, field, got, want);
      mismatches++;
   endtask

   task automatic clear_groups();
      for (int i = 0; i < MAX_GROUPS; i++) begin
         grp_open[i] = 1'b0;
         grp_key[i]  = '0;
         grp_aged[i] = 1'b0;
      end
      track_err = ERR_NONE;
   endtask

   task automatic latch_error(input logic [ErrW-1:0] code);
      if (track_err == ERR_NONE)
         track_err = code;
   endtask

   task automatic predict_verdict(input logic [DeltaW-1:0] delta, input logic [KindW-1:0] kind,
                                  input logic [IdW-1:0] id, input logic last);
      int             hit;
      int             free_idx;
      bit             any_open;
      logic [IdW-1:0] key;
      verdict_type    v;
      key      = id & KeyMask;
      hit      = -1;
      free_idx = -1;
      any_open = 0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
         if (grp_open[i]) begin
            if (delta != '0)
               grp_aged[i] = 1'b1;
            if (hit < 0 && grp_key[i] == key)
               hit = i;
         end else if (free_idx < 0) begin
            free_idx = i;
         end
      end
      case (kind)
         KIND_START: begin
            if (hit >= 0)
               latch_error(ERR_DUP_START);
            else if (free_idx < 0)
               latch_error(ERR_TABLE_FULL);
            else begin
               grp_open[free_idx] = 1'b1;
               grp_key[free_idx]  = key;
               grp_aged[free_idx] = 1'b0;
            end
         end
         KIND_ENCLOSED: begin
            if (hit < 0)
               latch_error(ERR_ORPHAN_ENCLOSED);
         end
         KIND_END: begin
            if (hit < 0)
               latch_error(ERR_ORPHAN_END);
            else if (!grp_aged[hit])
               latch_error(ERR_ZERO_DURATION);
            else begin
               grp_open[hit] = 1'b0;
               grp_aged[hit] = 1'b0;
            end
         end
         default: ;
      endcase
      if (last) begin
         for (int i = 0; i < MAX_GROUPS; i++)
            if (grp_open[i])
               any_open = 1;
         if (any_open)
            latch_error(ERR_OPEN_AT_END);
      end
      v.err       = track_err;
      v.track_end = last;
      v.track_ok  = last && (track_err == ERR_NONE);
      verdicts_due.push_back(v);
      if (last)
         clear_groups();
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         clear_groups();
         verdicts_due.delete();
      end else begin
         if (req_tvalid && req_tready)
            predict_verdict(req_tdata[DeltaW-1:0], req_tuser,
                            req_tdata[DeltaW+IdW-1:DeltaW], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_due.size() == 0) begin
               report_mismatch("unexpected response, error_code", rsp_tdata[ErrW-1:0], 0);
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_tdata[ErrW-1:0] !== want.err)
                  report_mismatch("error_code", rsp_tdata[ErrW-1:0], want.err);
               if (rsp_tdata[ErrW] !== want.track_ok)
                  report_mismatch("track_ok", rsp_tdata[ErrW], want.track_ok);
               if (rsp_tlast !== want.track_end)
                  report_mismatch("track_end", rsp_tlast, want.track_end);
               if (rsp_tdata[RspDataW-1:ErrW+1] !== '0)
                  report_mismatch("pad bits", rsp_tdata[RspDataW-1:ErrW+1], 0);
            end
         end
      end
      verdicts_pending = verdicts_due.size();
   end

endmodule

/* verif/tb_top.sv */
// tb_top: stimulus and verdict for group_nesting_checker_core.
// Drives directed and random event tracks under varying back-pressure;
// checking is done by group_nesting_checker_scoreboard. Depends on gnc_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gnc_pkg::*;

   localparam int MaxGroups  = MaxGroupsDef;
   localparam int CycleLimit = 1000000;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata;   // time_delta[31:0], group_id[47:32]
   logic [KindW-1:0]    req_tuser;   // grouping_kind[1:0]
   logic                req_tlast;   // last_event
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;   // error_code[2:0], track_ok[3], zero[7:4]
   logic                rsp_tlast;   // track_end
   int                  mismatches;
   int                  verdicts_pending;

   typedef struct {
      logic [IdW-1:0] id;
      bit             aged;
   } open_grp_type;

   open_grp_type open_grps[$];   // groups the block holds open right now
   int        tx_idle_pct;
   int        rx_idle_pct;
   int        requests_sent;
   int        rsp_seen;
   int        hold_left;
   bit        held;
   int        cycle_count;

   group_nesting_checker_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   group_nesting_checker_scoreboard scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast),
      .mismatches       (mismatches),
      .verdicts_pending (verdicts_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // response side: random stalls plus one long hold-off to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            rsp_seen++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!held && rsp_seen >= 1300) begin
            held      = 1;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   function automatic int find_open(input logic [IdW-1:0] id);
      foreach (open_grps[i])
         if (open_grps[i].id == id)
            return i;
      return -1;
   endfunction

   function automatic logic [IdW-1:0] fresh_id();
      logic [IdW-1:0] id;
      do
         id = IdW'($urandom_range(0, 65535));
      while (find_open(id) >= 0);
      return id;
   endfunction

   function automatic logic [DeltaW-1:0] pick_delta();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return '0;
      else if (r < 80)
         return DeltaW'($urandom_range(1, 7));
      return $urandom;
   endfunction

   task automatic issue(input logic [DeltaW-1:0] delta, input logic [KindW-1:0] kind,
                        input logic [IdW-1:0] id, input bit last);
      int k;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {id, delta};
      req_tuser  <= kind;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      requests_sent++;
      // keep track of which groups are open so random tracks stay mostly legal
      if (delta != '0)
         foreach (open_grps[i])
            open_grps[i].aged = 1;
      k = find_open(id);
      if (kind == KIND_START && k < 0 && open_grps.size() < MaxGroups)
         open_grps.push_back('{id, 0});
      else if (kind == KIND_END && k >= 0 && open_grps[k].aged)
         open_grps.delete(k);
      if (last)
         open_grps.delete();
   endtask

   task automatic run_track();
      int             len;
      int             r;
      int             k;
      logic [IdW-1:0] id;
      if ($urandom_range(0, 99) < 10)
         for (int i = 0; i <= MaxGroups; i++)
            issue(pick_delta(), KIND_START, fresh_id(), 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      for (int n = 0; n < len; n++) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            id = IdW'($urandom_range(0, 65535));
            if (open_grps.size() > 0 && $urandom_range(0, 1))
               id = open_grps[$urandom_range(0, open_grps.size() - 1)].id;
            issue(pick_delta(), KindW'($urandom_range(0, 3)), id, 0);
         end else if (r < 16) begin
            issue(pick_delta(), KIND_NONE, IdW'($urandom_range(0, 65535)), 0);
         end else if (open_grps.size() == 0 || (open_grps.size() < MaxGroups && r < 45)) begin
            issue(pick_delta(), KIND_START, fresh_id(), 0);
         end else begin
            k = $urandom_range(0, open_grps.size() - 1);
            if (r < 70)
               issue(pick_delta(), KIND_ENCLOSED, open_grps[k].id, 0);
            else
               issue(open_grps[k].aged ? pick_delta() : DeltaW'($urandom_range(1, 1000)),
                     KIND_END, open_grps[k].id, 0);
         end
      end
      if ($urandom_range(0, 99) < 80) begin
         if (open_grps.size() == 0)
            issue(pick_delta(), KIND_NONE, IdW'($urandom_range(0, 65535)), 1);
         while (open_grps.size() > 0)
            issue(open_grps[0].aged ? pick_delta() : DeltaW'($urandom_range(1, 100)),
                  KIND_END, open_grps[0].id, open_grps.size() == 1);
      end else begin
         issue(pick_delta(), KindW'($urandom_range(0, 3)), IdW'($urandom_range(0, 65535)), 1);
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      req_tuser     <= KIND_NONE;
      req_tlast     <= 1'b0;
      tx_idle_pct   = 25;
      rx_idle_pct   = 82;
      requests_sent = 0;
      rsp_seen      = 0;
      hold_left     = 0;
      held          = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // clean track with enclosed and ungrouped events
      issue('0, KIND_START, 16'h0000, 0);
      issue('0, KIND_ENCLOSED, 16'h0000, 0);
      issue('1, KIND_NONE, 16'h1234, 0);
      issue('0, KIND_END, 16'h0000, 1);
      // duplicate start
      issue('1, KIND_START, 16'hFFFF, 0);
      issue('0, KIND_START, 16'hFFFF, 0);
      issue(32'd3, KIND_END, 16'hFFFF, 1);
      // end with no elapsed time, group stays open until a later end
      issue('0, KIND_START, 16'h8001, 0);
      issue('0, KIND_END, 16'h8001, 0);
      issue(32'd2, KIND_END, 16'h8001, 1);
      // orphan enclosed
      issue('0, KIND_ENCLOSED, 16'h1234, 0);
      issue('0, KIND_NONE, 16'h0000, 1);
      // orphan end
      issue(32'd1, KIND_END, 16'h5555, 1);
      // group left open at the end of the track
      issue('0, KIND_START, 16'hAAAA, 1);
      // empty track
      issue('0, KIND_NONE, 16'h0000, 1);

      while (requests_sent < 620)
         run_track();
      tx_idle_pct = 82;
      rx_idle_pct = 25;
      while (requests_sent < 1240)
         run_track();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      while (requests_sent < 1850)
         run_track();
      req_tvalid <= 1'b0;

      do
         @(posedge clock);
      while (verdicts_pending != 0);
      repeat (2 * MaxGroups + 8) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
